[sv/lkvc_pkg.sv]
// Package for the LRU key-value cache.
// Holds sizes, word types and the command and status structs shared by the modules.
// Depends on nothing.
package lkvc_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } rsp_t;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_STORE  = 1'b1;

    typedef struct packed {
        logic load_req;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_addr;
    } stat_t;

endpackage

[sv/lkvc_req_if.sv]
// Request channel of the LRU key-value cache: valid, ready and one request word.
// Depends on lkvc_pkg.
interface lkvc_req_if;
    logic          valid;
    logic          ready;
    lkvc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/lkvc_rsp_if.sv]
// Response channel of the LRU key-value cache: valid, ready and one result word.
// Depends on lkvc_pkg.
interface lkvc_rsp_if;
    logic          valid;
    logic          ready;
    lkvc_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/lru_key_value_cache_top.sv]
// One request word is accepted, then the block sweeps all CAPACITY entries of its key, value
// and rank memories at one entry per cycle through a single read port; the read pipeline then
// drains (ST_DRAIN) and the result is committed (ST_COMMIT). The result is held in an output
// register: the next request is accepted while it waits, and only the commit of that next
// request stalls until the result has been taken. Valid bits are flip-flops cleared by reset,
// so no clearing pass runs.
// Top level of the LRU key-value cache; depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if,
// lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_top (
    input logic        clk,
    input logic        rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp
);
    import lkvc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_data (req.data),
        .rsp_data (rsp.data)
    );

endmodule

[sv/lkvc_ctrl.sv]
// Controller of the LRU key-value cache: request sequencing and result handshake.
// Depends on lkvc_pkg; drives the datapath through cmd_t and reads stat_t.
module lkvc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  lkvc_pkg::stat_t stat,
    output lkvc_pkg::cmd_t  cmd
);
    import lkvc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = out_valid_reg;
    assign cmd.load_req  = req_valid && req_ready;
    assign cmd.scan_step = (state_reg == ST_SCAN);
    assign cmd.commit    = (state_reg == ST_COMMIT) && (!out_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load_req)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (stat.last_addr)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (cmd.commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[sv/lkvc_datapath.sv]
// Datapath of the LRU key-value cache: entry memories, valid bits, sweep and result register.
// Depends on lkvc_pkg; commanded by lkvc_ctrl through cmd_t.
module lkvc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  lkvc_pkg::cmd_t  cmd,
    output lkvc_pkg::stat_t stat,
    input  lkvc_pkg::req_t  req_data,
    output lkvc_pkg::rsp_t  rsp_data
);
    import lkvc_pkg::*;

    // Recency is updated lazily: the rank change of one request is applied
    // while the next request sweeps the rank memory.
    logic [KEY_W-1:0]  key_mem  [CAPACITY];
    logic [VAL_W-1:0]  val_mem  [CAPACITY];
    logic [RANK_W-1:0] rank_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [CNT_W-1:0]  count_reg;

    req_t              req_reg;
    rsp_t              rsp_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              chk_en_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg;

    logic              pend_reg;
    logic              pend_ins_reg;
    logic [IDX_W-1:0]  pend_slot_reg;
    logic [RANK_W-1:0] pend_rank_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  match_slot_reg;
    logic [RANK_W-1:0] match_rank_reg;
    logic [VAL_W-1:0]  match_val_reg;
    logic              lru_found_reg;
    logic [IDX_W-1:0]  lru_slot_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_slot_reg;

    logic              chk_valid;
    logic [RANK_W-1:0] new_rank;
    logic              is_store;
    logic              full;
    logic              do_evict;
    logic              use_free;
    logic              do_insert;
    logic [IDX_W-1:0]  ins_slot;

    assign stat.last_addr = (idx_reg == IDX_W'(CAPACITY - 1));
    assign rsp_data       = rsp_reg;
    assign chk_valid      = valid_reg[chk_idx_reg];

    always_comb
    begin
        new_rank = rank_rd_reg;
        if (pend_reg)
        begin
            if (chk_idx_reg == pend_slot_reg)
            begin
                new_rank = '0;
            end
            else if (chk_valid && (pend_ins_reg || (rank_rd_reg < pend_rank_reg)))
            begin
                new_rank = rank_rd_reg + 1'b1;
            end
        end
    end

    assign is_store  = (req_reg.mode == MODE_STORE);
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign do_evict  = is_store && !found_reg && full && lru_found_reg;
    assign use_free  = is_store && !found_reg && !do_evict && free_found_reg;
    assign do_insert = do_evict || use_free;
    assign ins_slot  = do_evict ? lru_slot_reg : free_slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.scan_step)
        begin
            key_rd_reg  <= key_mem[idx_reg];
            val_rd_reg  <= val_mem[idx_reg];
            rank_rd_reg <= rank_mem[idx_reg];
            chk_idx_reg <= idx_reg;
        end
        if (chk_en_reg)
        begin
            rank_mem[chk_idx_reg] <= new_rank;
        end
        if (cmd.commit)
        begin
            if (found_reg && is_store)
            begin
                val_mem[match_slot_reg] <= req_reg.store_value;
            end
            else if (do_insert)
            begin
                key_mem[ins_slot] <= req_reg.key;
                val_mem[ins_slot] <= req_reg.store_value;
            end
            rsp_reg.hit        <= found_reg;
            rsp_reg.read_value <= (found_reg && !is_store) ? match_val_reg : '0;
            rsp_reg.evicted    <= do_evict;
            pend_ins_reg       <= !found_reg;
            pend_slot_reg      <= found_reg ? match_slot_reg : ins_slot;
            pend_rank_reg      <= match_rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            chk_en_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            match_slot_reg <= '0;
            match_rank_reg <= '0;
            match_val_reg  <= '0;
            lru_found_reg  <= 1'b0;
            lru_slot_reg   <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
        end
        else
        begin
            chk_en_reg <= cmd.scan_step;

            if (cmd.load_req)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step && !stat.last_addr)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd.load_req)
            begin
                found_reg      <= 1'b0;
                lru_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (chk_en_reg)
            begin
                if (chk_valid && (key_rd_reg == req_reg.key) && !found_reg)
                begin
                    found_reg      <= 1'b1;
                    match_slot_reg <= chk_idx_reg;
                    match_rank_reg <= new_rank;
                    match_val_reg  <= val_rd_reg;
                end
                if (chk_valid && (new_rank == RANK_W'(CAPACITY - 1)) && !lru_found_reg)
                begin
                    lru_found_reg <= 1'b1;
                    lru_slot_reg  <= chk_idx_reg;
                end
                if (!chk_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= chk_idx_reg;
                end
            end

            if (cmd.commit)
            begin
                pend_reg <= found_reg || do_insert;
                if (do_insert)
                begin
                    valid_reg[ins_slot] <= 1'b1;
                end
                if (use_free)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

endmodule

[sv/lkvc_checker.sv]
// Port-level checks of the LRU key-value cache and the bind that attaches them.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lkvc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input lkvc_pkg::rsp_t rsp_data
);
    import lkvc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word changed while stalled");

    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
        else $error("hit and eviction reported together");

    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.read_value != '0) |-> rsp_data.hit && !rsp_data.evicted)
        else $error("nonzero value without a lookup hit");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a sweep is starting");

endmodule

bind lru_key_value_cache_top lkvc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[bench/lkvc_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the LRU key-value cache bench: it keeps its own copy of the cache contents and
// recency order, and compares every result word with the prediction made when its request
// word was accepted. Depends on lkvc_pkg, lkvc_req_if and lkvc_rsp_if.
module lkvc_result_checker (
    input  logic clk,
    input  logic rst_n,
    lkvc_req_if  req,
    lkvc_rsp_if  rsp,
    output int   failures,
    output int   pending,
    output int   lookups,
    output int   hits,
    output int   stores,
    output int   evictions
);

    logic [lkvc_pkg::KEY_W-1:0] cached_key [lkvc_pkg::CAPACITY];
    logic [lkvc_pkg::VAL_W-1:0] cached_value [lkvc_pkg::CAPACITY];
    bit                         cached_valid [lkvc_pkg::CAPACITY];
    int                         recency [lkvc_pkg::CAPACITY];
    int                         fill_level;
    int                         checked;
    lkvc_pkg::rsp_t             awaited_rsp [$];
    lkvc_pkg::rsp_t             want;

    task automatic report_mismatch(input string msg);
        if (failures < 40)
        begin
            $display("Mismatch at result %0d: %s", checked, msg);
        end
        failures++;
    endtask

    function automatic lkvc_pkg::rsp_t serve_request(input lkvc_pkg::req_t r);
        lkvc_pkg::rsp_t res;
        int slot;
        int old_rank;
        res = '0;
        slot = -1;
        for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
        begin
            if (slot < 0 && cached_valid[i] && cached_key[i] == r.key)
            begin
                slot = i;
            end
        end
        if (slot >= 0)
        begin
            res.hit = 1'b1;
            if (r.mode == lkvc_pkg::MODE_LOOKUP)
            begin
                res.read_value = cached_value[slot];
            end
            else
            begin
                cached_value[slot] = r.store_value;
            end
            old_rank = recency[slot];
            for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
            begin
                if (cached_valid[i] && recency[i] < old_rank)
                begin
                    recency[i]++;
                end
            end
            recency[slot] = 0;
        end
        else if (r.mode == lkvc_pkg::MODE_STORE)
        begin
            if (fill_level >= lkvc_pkg::CAPACITY)
            begin
                for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                begin
                    if (slot < 0 && cached_valid[i] && recency[i] == lkvc_pkg::CAPACITY - 1)
                    begin
                        slot = i;
                    end
                end
            end
            if (slot >= 0)
            begin
                cached_valid[slot] = 1'b0;
                fill_level--;
                res.evicted = 1'b1;
            end
            else
            begin
                for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                begin
                    if (slot < 0 && !cached_valid[i])
                    begin
                        slot = i;
                    end
                end
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
                begin
                    if (cached_valid[i])
                    begin
                        recency[i]++;
                    end
                end
                cached_key[slot] = r.key;
                cached_value[slot] = r.store_value;
                cached_valid[slot] = 1'b1;
                recency[slot] = 0;
                fill_level++;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lkvc_pkg::CAPACITY; i++)
            begin
                cached_valid[i] = 1'b0;
                recency[i] = 0;
            end
            fill_level = 0;
            checked = 0;
            awaited_rsp.delete();
            failures = 0;
            lookups = 0;
            hits = 0;
            stores = 0;
            evictions = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch($sformatf("result word %0h arrived with none expected",
                                              rsp.data));
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.data.hit !== want.hit)
                    begin
                        report_mismatch($sformatf("hit %0b, expected %0b",
                                                  rsp.data.hit, want.hit));
                    end
                    if (rsp.data.read_value !== want.read_value)
                    begin
                        report_mismatch($sformatf("read_value %0h, expected %0h",
                                                  rsp.data.read_value, want.read_value));
                    end
                    if (rsp.data.evicted !== want.evicted)
                    begin
                        report_mismatch($sformatf("evicted %0b, expected %0b",
                                                  rsp.data.evicted, want.evicted));
                    end
                end
                checked++;
            end
            if (req.valid && req.ready)
            begin
                if (req.data.mode == lkvc_pkg::MODE_STORE)
                begin
                    stores++;
                end
                else
                begin
                    lookups++;
                end
                want = serve_request(req.data);
                hits += want.hit;
                evictions += want.evicted;
                awaited_rsp.push_back(want);
            end
            pending <= awaited_rsp.size();
        end
    end

endmodule

[bench/lru_key_value_cache_top_test.sv]
`timescale 1ns / 1ps
// Top of the LRU key-value cache bench: clock, reset, request words and result back-pressure.
// Prediction and comparison live in lkvc_result_checker; depends on lkvc_pkg, lkvc_req_if,
// lkvc_rsp_if and lru_key_value_cache_top.
module lru_key_value_cache_top_test;

    import lkvc_pkg::*;

    localparam int ITEMS       = 1900;
    localparam int KEY_POOL    = 192;
    localparam int HOLD_CYCLES = 700;
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   lookups;
    int   hits;
    int   stores;
    int   evictions;
    bit   steady;
    int   hold_asks;
    int   hold_done;
    int   quiet_cycles;

    logic [KEY_W-1:0] key_pool [KEY_POOL];

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lkvc_result_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .failures  (failures),
        .pending   (pending),
        .lookups   (lookups),
        .hits      (hits),
        .stores    (stores),
        .evictions (evictions)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_asks != hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            else if (!steady && $urandom_range(99) < 30)
            begin
                rsp_ch.ready <= 1'b0;
                n = ($urandom_range(49) == 0) ? $urandom_range(8, 24) : 1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer(input logic mode, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
        req_t w;
        w.mode = mode;
        w.key = key;
        w.store_value = value;
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic sender_gap();
        int n;
        if (!steady && $urandom_range(99) < 34)
        begin
            req_ch.valid <= 1'b0;
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(100, 380);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic offer_random(input int span);
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic mode;
        mode = $urandom_range(1) ? MODE_STORE : MODE_LOOKUP;
        if ($urandom_range(99) < 15)
        begin
            key = {$urandom, $urandom};
        end
        else
        begin
            key = key_pool[$urandom_range(span - 1)];
        end
        case ($urandom_range(15))
            0: value = '0;
            1: value = '1;
            default: value = $urandom;
        endcase
        offer(mode, key, value);
    endtask

    initial
    begin
        int span;
        rst_n = 1'b0;
        steady = 1'b0;
        hold_asks = 0;
        hold_done = 0;
        quiet_cycles = 0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(MODE_LOOKUP, '0, '1);
        offer(MODE_STORE, '0, 32'hFFFF_FFFF);
        sender_gap();
        offer(MODE_STORE, '1, 32'h0000_0000);
        offer(MODE_LOOKUP, '1, 32'h5A5A_5A5A);
        offer(MODE_LOOKUP, '0, 32'h0000_0000);
        sender_gap();
        offer(MODE_STORE, '0, 32'h1234_5678);
        offer(MODE_LOOKUP, '0, 32'hFFFF_FFFF);
        offer(MODE_LOOKUP, 64'h8000_0000_0000_0000, 32'h0000_0001);
        offer(MODE_LOOKUP, 64'h0000_0000_0000_0001, 32'h0000_0000);
        offer(MODE_STORE, 64'h8000_0000_0000_0000, 32'h8000_0000);
        offer(MODE_LOOKUP, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
        offer(MODE_STORE, '1, 32'hC0A8_0001);
        offer(MODE_LOOKUP, '1, 32'h0000_0000);

        for (int i = 0; i < ITEMS - 13; i++)
        begin
            span = (i < 300) ? 48 : (i < 1100) ? KEY_POOL : 136;
            steady = (i >= 1000 && i < 1300);
            if (i == 500 || i == 1400)
            begin
                wait_drained();
            end
            if (i == 800 || i == 1600)
            begin
                hold_asks++;
            end
            offer_random(span);
            sender_gap();
        end

        wait_drained();
        repeat (CAPACITY + 20) @(posedge clk);
        $display("Covered %0d lookups with %0d hits and %0d stores with %0d evictions,",
                 lookups, hits, stores, evictions);
        $display("through receiver hold-offs, sender drain pauses and a back-to-back stretch.");
        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[lru_key_value_cache_top.f]
sv/lkvc_pkg.sv
sv/lkvc_req_if.sv
sv/lkvc_rsp_if.sv
sv/lkvc_ctrl.sv
sv/lkvc_datapath.sv
sv/lru_key_value_cache_top.sv
sv/lkvc_checker.sv
bench/lkvc_result_checker.sv
bench/lru_key_value_cache_top_test.sv
